/* rtl/recharge_series_statistics_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef RECHARGE_SERIES_STATISTICS_ASSERT_SVH
`define RECHARGE_SERIES_STATISTICS_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define RSS_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rss_pkg.sv */
package rss_pkg;

   localparam int SERIES_DEPTH_DEFAULT = 16;
   localparam int FIXED_SHIFT_DEFAULT  = 3;
   localparam int BLEND_SHIFT_DEFAULT  = 2;

   localparam logic [31:0] WINDOW_RESET = 32'd65536;

   localparam logic [1:0] SEL_RECHARGE = 2'd0;
   localparam logic [1:0] SEL_UPTIME   = 2'd1;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_DRAIN,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] recharge_len;
      logic [31:0] up_time;
      logic [31:0] now;
      logic        use_window;
      logic [31:0] base;
      logic [1:0]  which_series;
   } req_type;

   typedef struct packed {
      logic [31:0] average;
      logic [31:0] ewma_recharge;
      logic        series_full;
   } rsp_type;

endpackage

/* rtl/recharge_series_statistics.sv */
// Record, clear and no-op transactions run execute, then finish loads the result.
// A query walks the n stored entries through the store memories, drains the last read
// and then runs the bit-serial divider; an empty query goes straight to the divider.
// A new transaction is taken only in idle; finish waits while a held rsp is stalled.
// Synchronous reset clears write pointer, full flag and EWMA and sets the window
// to 65536 ticks; the store memories are not cleared and need no clearing pass.
module recharge_series_statistics #(
   parameter int SERIES_DEPTH = rss_pkg::SERIES_DEPTH_DEFAULT,
   parameter int FIXED_SHIFT  = rss_pkg::FIXED_SHIFT_DEFAULT,
   parameter int BLEND_SHIFT  = rss_pkg::BLEND_SHIFT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rss_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import rss_pkg::*;

   localparam int PTR_W = $clog2(SERIES_DEPTH);
   localparam int CNT_W = $clog2(SERIES_DEPTH + 1);

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             full_ff, full_in;
   logic [31:0]      ewma_ff, ewma_in;
   logic [31:0]      window_ff, window_in;

   logic [31:0]      cutoff_ff, cutoff_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [PTR_W-1:0] walk_ff, walk_in;
   logic             rd_live_ff, rd_live_in;
   logic             rd_first_ff, rd_first_in;
   logic [31:0]      sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      newest_stamp_ff, newest_stamp_in;
   logic [31:0]      newest_val_ff, newest_val_in;
   logic [31:0]      quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [4:0]       step_ff, step_in;

   logic [31:0] rech_mem  [SERIES_DEPTH];
   logic [31:0] up_mem    [SERIES_DEPTH];
   logic [31:0] stamp_mem [SERIES_DEPTH];
   logic [31:0] rech_q_ff, up_q_ff, stamp_q_ff;

   logic             mem_we;
   logic             rsp_load;
   logic [CNT_W-1:0] n_now;
   logic             walk_last;
   logic [31:0]      sel_val;
   logic             take;
   logic             newer;
   logic [31:0]      sum_acc;
   logic [CNT_W-1:0] cnt_acc;
   logic [31:0]      rech_fixed;
   logic [31:0]      blend_sum;
   logic [CNT_W:0]   shifted;
   logic [CNT_W:0]   diff;
   logic             ge;

   assign n_now     = full_ff ? CNT_W'(SERIES_DEPTH) : CNT_W'(ptr_ff);
   assign walk_last = (CNT_W'(walk_ff) == n_ff - CNT_W'(1));

   always_comb begin
      case (req_ff.which_series)
         SEL_RECHARGE: sel_val = rech_q_ff;
         SEL_UPTIME:   sel_val = up_q_ff;
         default:      sel_val = stamp_q_ff;
      endcase
   end

   assign take    = rd_live_ff && (!req_ff.use_window || (cutoff_ff < stamp_q_ff));
   assign newer   = rd_live_ff && (rd_first_ff || (newest_stamp_ff < stamp_q_ff));
   assign sum_acc = sum_ff + (take ? sel_val : 32'd0);
   assign cnt_acc = cnt_ff + CNT_W'(take);

   // Blend (2^B - 1) * avg + f as (avg << B) - avg + f, all modulo 2^32.
   assign rech_fixed = req_ff.recharge_len << FIXED_SHIFT;
   assign blend_sum  = (ewma_ff << BLEND_SHIFT) - ewma_ff + rech_fixed;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = (shifted >= {1'b0, div_ff});

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (req_ff.cmd == CMD_QUERY) begin
               state_in = (n_now == '0) ? ST_DIV : ST_WALK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WALK: begin
            if (walk_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == 5'd31) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      csr_ready = 1'b1;
      mem_we    = (state_ff == ST_EXEC) && (req_ff.cmd == CMD_RECORD);
      rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      req_in          = req_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff;
      ptr_in          = ptr_ff;
      full_in         = full_ff;
      ewma_in         = ewma_ff;
      window_in       = window_ff;
      cutoff_in       = cutoff_ff;
      n_in            = n_ff;
      walk_in         = walk_ff;
      rd_live_in      = 1'b0;
      rd_first_in     = 1'b0;
      sum_in          = sum_ff;
      cnt_in          = cnt_ff;
      newest_stamp_in = newest_stamp_ff;
      newest_val_in   = newest_val_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      step_in         = step_ff;

      if (csr_valid) window_in = csr_data;
      if (req_valid && req_ready) req_in = req_data;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_in.average       = quo_ff;
         rsp_in.ewma_recharge = ewma_ff;
         rsp_in.series_full   = full_ff;
      end

      // Entries read in the previous cycle are folded in during both walk and drain.
      if (rd_live_ff) begin
         sum_in = sum_acc;
         cnt_in = cnt_acc;
         if (newer) begin
            newest_stamp_in = stamp_q_ff;
            newest_val_in   = sel_val;
         end
      end

      case (state_ff)
         ST_EXEC: begin
            quo_in  = 32'd0;
            sum_in  = 32'd0;
            cnt_in  = '0;
            walk_in = '0;
            n_in    = n_now;
            rem_in  = '0;
            step_in = 5'd0;
            div_in  = CNT_W'(1);
            cutoff_in = (window_ff < req_ff.now) ? (req_ff.now - window_ff) : 32'd0;
            case (req_ff.cmd)
               CMD_CLEAR: begin
                  ptr_in  = '0;
                  full_in = 1'b0;
                  ewma_in = 32'd0;
               end
               CMD_RECORD: begin
                  ewma_in = (ewma_ff == 32'd0) ? rech_fixed : (blend_sum >> BLEND_SHIFT);
                  if (ptr_ff == PTR_W'(SERIES_DEPTH - 1)) begin
                     ptr_in  = '0;
                     full_in = 1'b1;
                  end else begin
                     ptr_in = ptr_ff + PTR_W'(1);
                  end
               end
               CMD_QUERY: begin
                  // An empty series averages the base value over a count of one.
                  quo_in = req_ff.base << FIXED_SHIFT;
               end
               default: begin
               end
            endcase
         end
         ST_WALK: begin
            rd_live_in  = 1'b1;
            rd_first_in = (walk_ff == '0);
            walk_in     = walk_ff + PTR_W'(1);
         end
         ST_DRAIN: begin
            rem_in  = '0;
            step_in = 5'd0;
            if (!req_ff.use_window) begin
               quo_in = sum_acc << FIXED_SHIFT;
               div_in = n_ff;
            end else if (cnt_acc == '0) begin
               quo_in = (newer ? sel_val : newest_val_ff) << FIXED_SHIFT;
               div_in = CNT_W'(1);
            end else begin
               quo_in = sum_acc << FIXED_SHIFT;
               div_in = cnt_acc;
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[30:0], ge};
            rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            step_in = step_ff + 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         full_ff      <= 1'b0;
         ewma_ff      <= 32'd0;
         window_ff    <= WINDOW_RESET;
         rd_live_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         full_ff      <= full_in;
         ewma_ff      <= ewma_in;
         window_ff    <= window_in;
         rd_live_ff   <= rd_live_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      rsp_ff          <= rsp_in;
      cutoff_ff       <= cutoff_in;
      n_ff            <= n_in;
      walk_ff         <= walk_in;
      rd_first_ff     <= rd_first_in;
      sum_ff          <= sum_in;
      cnt_ff          <= cnt_in;
      newest_stamp_ff <= newest_stamp_in;
      newest_val_ff   <= newest_val_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      div_ff          <= div_in;
      step_ff         <= step_in;
   end

   // Store memories: one write port at the write pointer, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rech_mem[ptr_ff]  <= req_ff.recharge_len;
         up_mem[ptr_ff]    <= req_ff.up_time;
         stamp_mem[ptr_ff] <= req_ff.now;
      end
      rech_q_ff  <= rech_mem[walk_ff];
      up_q_ff    <= up_mem[walk_ff];
      stamp_q_ff <= stamp_mem[walk_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/rss_checker.sv */
`include "recharge_series_statistics_assert.svh"

module rss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rss_pkg::rsp_type rsp_data
);
   import rss_pkg::*;

   logic [2:0] pend_ff, pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Transactions accepted whose result has not yet been taken.
   always_comb begin
      pend_in = pend_ff + 3'(req_fire) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 3'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `RSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")
   `RSS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "block not idle after reset")
   `RSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "second transaction taken while busy")
   `RSS_ASSERT_NOW(a_pend_bound, clock, reset, pend_ff <= 3'd2, "more than two transactions in flight")
   `RSS_ASSERT_NOW(a_no_invented, clock, reset, !rsp_valid || (pend_ff != 3'd0), "result without a transaction")

endmodule

bind recharge_series_statistics rss_checker u_rss_checker (.*);
